// ===== design/recent_value_move_to_front_list_defines.svh =====
// assertion macros for the recent value move-to-front list
`ifndef RECENT_VALUE_MOVE_TO_FRONT_LIST_DEFINES_SVH
`define RECENT_VALUE_MOVE_TO_FRONT_LIST_DEFINES_SVH

// same-cycle implication
`define RVMTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVMTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rvmtf_pkg.sv =====
// shared constants for the recent value move-to-front list
`default_nettype none

package rvmtf_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_RESET_DEF   = 8;

  localparam int COLOR_W = 32;
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

endpackage

`default_nettype wire

// ===== design/rvmtf_cell.sv =====
// one list slot: holds a word, compares it with the pushed value, shifts from its neighbor
`default_nettype none

module rvmtf_cell
  import rvmtf_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               push,
  input  wire logic [COLOR_W-1:0] push_color,
  input  wire logic [COLOR_W-1:0] prev_word,
  input  wire logic [CW-1:0]      count,
  input  wire logic               hit_any,
  input  wire logic [IW-1:0]      hit_idx,
  output logic      [COLOR_W-1:0] word,
  output logic                    hit
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_I = IW'(IDX);

  logic [COLOR_W-1:0] word_r;
  logic               shift;

  // slots up to the hit (or all slots on a miss) move back one place
  assign shift = push && (!hit_any || (IDX_I <= hit_idx));
  assign hit   = (IDX_C < count) && (word_r == push_color);
  assign word  = word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= prev_word;
    end
  end

endmodule

`default_nettype wire

// ===== design/recent_value_move_to_front_list.sv =====
// top level of the recent value move-to-front list
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+----------------------
//  request  | in_func, in_color_value, in_read_position      | start & !busy
//  result   | out_was_present, out_old_position,             | out_valid, one cycle
//           | out_entry_count, out_read_color, out_read_valid|
//  config   | cfg_wdata (list capacity)                      | cfg_we
//
// one request per cycle while busy is low; its registered result appears in the cycle after acceptance
// every slot compares and shifts in the same cycle
// reset is synchronous; busy is high during reset and drops the cycle after
// busy never rises otherwise; the receiver cannot stall the result
`default_nettype none

module recent_value_move_to_front_list
  import rvmtf_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [COLOR_W-1:0] in_color_value,
  input  wire logic [POS_W-1:0]   in_read_position,
  input  wire logic               cfg_we,
  input  wire logic [CAP_W-1:0]   cfg_wdata,
  output logic                    out_valid,
  output logic                    out_was_present,
  output logic      [POS_W-1:0]   out_old_position,
  output logic      [COUNT_W-1:0] out_entry_count,
  output logic      [COLOR_W-1:0] out_read_color,
  output logic                    out_read_valid
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] CAP_RST =
    CW'((CAP_RESET_DEF < MAX_ENTRIES) ? CAP_RESET_DEF : MAX_ENTRIES);

  logic               busy_r;
  logic               out_valid_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      cap_r;
  logic [CW-1:0]      cap_nxt;

  logic               was_present_r;
  logic               was_present_nxt;
  logic [POS_W-1:0]   old_position_r;
  logic [POS_W-1:0]   old_position_nxt;
  logic [COUNT_W-1:0] entry_count_r;
  logic [COUNT_W-1:0] entry_count_nxt;
  logic [COLOR_W-1:0] read_color_r;
  logic [COLOR_W-1:0] read_color_nxt;
  logic               read_valid_r;
  logic               read_valid_nxt;

  logic               accept;
  logic               push_go;

  logic [COLOR_W-1:0] word_w [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit_w;
  logic               hit_any;
  logic [IW-1:0]      hit_idx;

  logic [7:0]         cfg_d8;
  logic [7:0]         cap_eff8;
  logic [IW+3:0]      rpos_ext;
  logic [IW+3:0]      oldpos_ext;
  logic [CW+4:0]      count_ext;
  logic               rd_ok;

  assign accept  = start && !busy_r;
  assign push_go = accept && (in_func == FUNC_PUSH);

  // slot chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [COLOR_W-1:0] prev_word;
    if (i == 0) begin : g_head
      assign prev_word = in_color_value;
    end else begin : g_body
      assign prev_word = word_w[i-1];
    end

    rvmtf_cell #(
      .CW  (CW),
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .push       (push_go),
      .push_color (in_color_value),
      .prev_word  (prev_word),
      .count      (count_r),
      .hit_any    (hit_any),
      .hit_idx    (hit_idx),
      .word       (word_w[i]),
      .hit        (hit_w[i])
    );
  end

  // valid entries are unique, so at most one slot hits
  assign hit_any = |hit_w;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_w[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // capacity clamp
  assign cfg_d8   = 8'(cfg_wdata);
  assign cap_eff8 = (cfg_d8 == 8'd0) ? 8'd1 :
                    ((cfg_d8 > 8'(MAX_ENTRIES)) ? 8'(MAX_ENTRIES) : cfg_d8);
  assign cap_nxt  = cap_eff8[CW-1:0];

  assign rpos_ext   = {{IW{1'b0}}, in_read_position};
  assign oldpos_ext = {4'b0000, hit_idx};
  assign rd_ok      = (8'(in_read_position) < 8'(count_r)) &&
                      (8'(in_read_position) < 8'(MAX_ENTRIES));

  always_comb begin
    count_nxt        = count_r;
    was_present_nxt  = 1'b0;
    old_position_nxt = '0;
    read_color_nxt   = '0;
    read_valid_nxt   = 1'b0;
    unique case (in_func)
      FUNC_PUSH: begin
        was_present_nxt = hit_any;
        if (hit_any) begin
          old_position_nxt = oldpos_ext[POS_W-1:0];
        end else if (count_r < cap_r) begin
          count_nxt = count_r + CW'(1);
        end
      end
      FUNC_CLEAR: begin
        count_nxt = '0;
      end
      FUNC_READ: begin
        if (rd_ok) begin
          read_valid_nxt = 1'b1;
          read_color_nxt = word_w[rpos_ext[IW-1:0]];
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign count_ext       = {5'b00000, count_nxt};
  assign entry_count_nxt = count_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      cap_r       <= CAP_RST;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (cfg_we) begin
        cap_r <= cap_nxt;
        if (count_r > cap_nxt) begin
          count_r <= cap_nxt;
        end
      end else if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      was_present_r  <= was_present_nxt;
      old_position_r <= old_position_nxt;
      entry_count_r  <= entry_count_nxt;
      read_color_r   <= read_color_nxt;
      read_valid_r   <= read_valid_nxt;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_was_present  = was_present_r;
  assign out_old_position = old_position_r;
  assign out_entry_count  = entry_count_r;
  assign out_read_color   = read_color_r;
  assign out_read_valid   = read_valid_r;

endmodule

`default_nettype wire

// ===== design/rvmtf_checker.sv =====
// port-level checks for the recent value move-to-front list, bound to the top level
`default_nettype none

`include "recent_value_move_to_front_list_defines.svh"

module rvmtf_checker
  import rvmtf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [FUNC_W-1:0]  in_func,
  input wire logic [POS_W-1:0]   in_read_position,
  input wire logic               out_valid,
  input wire logic               out_was_present,
  input wire logic [POS_W-1:0]   out_old_position,
  input wire logic [COUNT_W-1:0] out_entry_count,
  input wire logic [COLOR_W-1:0] out_read_color,
  input wire logic               out_read_valid
);

  logic req;
  assign req = start && !busy;

  `RVMTF_ASSERT_NEXT(a_one_result, clk, rst_n, 1'b1,
    out_valid == $past(req), "result strobe does not follow request")
  `RVMTF_ASSERT_NEXT(a_clear_empties, clk, rst_n, req && (in_func == FUNC_CLEAR),
    out_entry_count == '0, "clear left entries")
  `RVMTF_ASSERT_NEXT(a_read_bound, clk, rst_n, req && (in_func == FUNC_READ),
    out_read_valid == (5'($past(in_read_position)) < out_entry_count),
    "read valid disagrees with count")
  `RVMTF_ASSERT_NOW(a_read_zero, clk, rst_n, out_valid && !out_read_valid,
    out_read_color == '0, "invalid read returned data")
  `RVMTF_ASSERT_NOW(a_absent_pos, clk, rst_n, out_valid && !out_was_present,
    out_old_position == '0, "old position set without hit")

endmodule

bind recent_value_move_to_front_list rvmtf_checker u_rvmtf_checker (.*);

`default_nettype wire

// ===== sim/recent_value_move_to_front_list_checker.sv =====
// checker for the move-to-front list: predicts each request's result and compares it
module recent_value_move_to_front_list_checker
  import rvmtf_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [COLOR_W-1:0] in_color_value,
  input  logic [POS_W-1:0]   in_read_position,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic               out_valid,
  input  logic               out_was_present,
  input  logic [POS_W-1:0]   out_old_position,
  input  logic [COUNT_W-1:0] out_entry_count,
  input  logic [COLOR_W-1:0] out_read_color,
  input  logic               out_read_valid,
  output int                 fail_count,
  output int                 pending_count,
  output int                 hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               was_present;
    logic [POS_W-1:0]   old_position;
    logic [COUNT_W-1:0] entry_count;
    logic [COLOR_W-1:0] read_color;
    logic               read_valid;
  } list_result_t;

  logic [COLOR_W-1:0] list_words [MAX_ENTRIES];
  int                 list_count = 0;
  logic [CAP_W-1:0]   capacity_reg = CAP_W'(CAP_RESET_DEF);
  list_result_t       expected_results [$];
  int                 fails = 0;
  int                 hits = 0;

  initial begin
    foreach (list_words[k]) list_words[k] = '0;
  end

  function automatic int kept_entries(logic [CAP_W-1:0] cap);
    int c;
    c = int'(cap);
    if (c == 0) c = 1;
    if (c > MAX_ENTRIES) c = MAX_ENTRIES;
    return c;
  endfunction

  function automatic list_result_t apply_request(logic [FUNC_W-1:0] func,
                                                 logic [COLOR_W-1:0] color,
                                                 logic [POS_W-1:0] pos);
    list_result_t r;
    int limit, n, slot, hit_pos, i;
    bit found;
    r = '0;
    case (func)
      FUNC_PUSH: begin
        limit = kept_entries(capacity_reg);
        n = list_count;
        if (n > limit) n = limit;
        slot = n;
        hit_pos = 0;
        found = 0;
        for (i = 0; i < n; i++) begin
          if (!found && list_words[i] == color) begin
            found = 1;
            hit_pos = i;
            slot = i;
          end
        end
        if (!found && n < limit) n++;
        if (slot >= n) slot = n - 1;
        for (i = slot; i > 0; i--) list_words[i] = list_words[i-1];
        list_words[0] = color;
        list_count = n;
        r.was_present = found;
        r.old_position = POS_W'(hit_pos);
        if (found) hits++;
      end
      FUNC_CLEAR: begin
        list_count = 0;
      end
      FUNC_READ: begin
        if (int'(pos) < list_count && int'(pos) < MAX_ENTRIES) begin
          r.read_valid = 1'b1;
          r.read_color = list_words[pos];
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(list_count);
    return r;
  endfunction

  task automatic report_failure(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    list_result_t oldest;
    int limit;
    if (!rst_n) begin
      list_count = 0;
      capacity_reg = CAP_W'(CAP_RESET_DEF);
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_failure("result with no request outstanding");
        end else begin
          oldest = expected_results.pop_front();
          if (out_was_present !== oldest.was_present)
            report_failure($sformatf("was_present got %0b expected %0b",
                                     out_was_present, oldest.was_present));
          if (out_old_position !== oldest.old_position)
            report_failure($sformatf("old_position got %0d expected %0d",
                                     out_old_position, oldest.old_position));
          if (out_entry_count !== oldest.entry_count)
            report_failure($sformatf("entry_count got %0d expected %0d",
                                     out_entry_count, oldest.entry_count));
          if (out_read_color !== oldest.read_color)
            report_failure($sformatf("read_color got %08h expected %08h",
                                     out_read_color, oldest.read_color));
          if (out_read_valid !== oldest.read_valid)
            report_failure($sformatf("read_valid got %0b expected %0b",
                                     out_read_valid, oldest.read_valid));
        end
      end
      if (cfg_we) begin
        capacity_reg = cfg_wdata;
        limit = kept_entries(capacity_reg);
        if (list_count > limit) list_count = limit;
      end
      if (start && !busy)
        expected_results.push_back(apply_request(in_func, in_color_value, in_read_position));
    end
    fail_count <= fails;
    pending_count <= expected_results.size();
    hit_count <= hits;
  end

endmodule

// ===== sim/recent_value_move_to_front_list_tb.sv =====
// testbench top for the move-to-front list: drives requests and capacity writes, gives the verdict
module recent_value_move_to_front_list_tb;
  import rvmtf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 95;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [FUNC_W-1:0]  in_func = '0;
  logic [COLOR_W-1:0] in_color_value = '0;
  logic [POS_W-1:0]   in_read_position = '0;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  logic               out_valid;
  logic               out_was_present;
  logic [POS_W-1:0]   out_old_position;
  logic [COUNT_W-1:0] out_entry_count;
  logic [COLOR_W-1:0] out_read_color;
  logic               out_read_valid;

  int fail_count;
  int pending_count;
  int hit_count;
  int idle_cycles = 0;
  int burst_left = 0;
  int requests_by_func [4] = '{0, 0, 0, 0};
  int capacity_writes = 0;

  always #6 clk = ~clk;

  recent_value_move_to_front_list uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_color_value   (in_color_value),
    .in_read_position (in_read_position),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_was_present  (out_was_present),
    .out_old_position (out_old_position),
    .out_entry_count  (out_entry_count),
    .out_read_color   (out_read_color),
    .out_read_valid   (out_read_valid)
  );

  recent_value_move_to_front_list_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_color_value   (in_color_value),
    .in_read_position (in_read_position),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_was_present  (out_was_present),
    .out_old_position (out_old_position),
    .out_entry_count  (out_entry_count),
    .out_read_color   (out_read_color),
    .out_read_valid   (out_read_valid),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .hit_count        (hit_count)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("no request or result for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [COLOR_W-1:0] c,
                              input logic [POS_W-1:0] p);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_color_value <= c;
    in_read_position <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_by_func[f]++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_writes++;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int items);
    logic [COLOR_W-1:0] pool [24];
    int pool_size, k, r;
    write_capacity(cap);
    pool_size = $urandom_range(3, 24);
    for (k = 0; k < 24; k++) pool[k] = $urandom;
    for (k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 58)
        send_request(FUNC_PUSH, pool[$urandom_range(0, pool_size - 1)], POS_W'($urandom));
      else if (r < 68)
        send_request(FUNC_PUSH, $urandom, POS_W'($urandom));
      else if (r < 92)
        send_request(FUNC_READ, $urandom, POS_W'($urandom));
      else if (r < 96)
        send_request(FUNC_CLEAR, $urandom, POS_W'($urandom));
      else
        send_request(FUNC_UNUSED, $urandom, POS_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [10];
    int k;
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd5, 5'd12, 5'd8, 5'd3, 5'd16};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset capacity
    send_request(FUNC_READ, 32'h0, 4'd0);
    send_request(FUNC_PUSH, 32'h0000_0000, 4'd0);
    send_request(FUNC_PUSH, 32'hFFFF_FFFF, 4'hF);
    send_request(FUNC_PUSH, 32'h1234_5678, 4'd0);
    send_request(FUNC_PUSH, 32'hFFFF_FFFF, 4'd0);
    send_request(FUNC_PUSH, 32'h0000_0000, 4'd0);
    send_request(FUNC_READ, 32'hFFFF_FFFF, 4'd0);
    send_request(FUNC_READ, 32'h0, 4'd2);
    send_request(FUNC_READ, 32'h0, 4'hF);
    send_request(FUNC_CLEAR, 32'h0, 4'd0);
    send_request(FUNC_READ, 32'h0, 4'd0);
    send_request(FUNC_UNUSED, 32'hDEAD_BEEF, 4'd5);
    for (k = 0; k < 9; k++) send_request(FUNC_PUSH, 32'hA000_0000 + k, 4'd0);
    send_request(FUNC_PUSH, 32'hA000_0001, 4'd0);
    send_request(FUNC_READ, 32'h0, 4'd7);
    send_request(FUNC_READ, 32'h0, 4'd8);

    for (k = 0; k < 10; k++) run_phase(phase_caps[k], PHASE_ITEMS);

    drain();
    $display("%0d requests: %0d push (%0d hit an existing entry), %0d clear, %0d read, %0d unused",
             requests_by_func[0] + requests_by_func[1] + requests_by_func[2] +
             requests_by_func[3], requests_by_func[FUNC_PUSH], hit_count,
             requests_by_func[FUNC_CLEAR], requests_by_func[FUNC_READ],
             requests_by_func[FUNC_UNUSED]);
    $display("capacity written %0d times, values 0, 1, 16, 17 and 31 among them",
             capacity_writes);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rvmtf_pkg.sv
design/rvmtf_cell.sv
design/recent_value_move_to_front_list.sv
design/rvmtf_checker.sv
sim/recent_value_move_to_front_list_checker.sv
sim/recent_value_move_to_front_list_tb.sv
